FILE: rtl/mcpid_pkg.sv
`default_nettype none

package mcpid_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = 3;
  localparam int VAL_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int ERR_W    = VAL_W + 1;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int INT_W    = ERR_W;
  localparam int MUL_W    = 24;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int WPROD_W  = GAIN_W + INT_W;
  localparam int SUM_W    = 38;
  localparam int N_W      = SUM_W + 7;
  localparam int M9_W     = 20;
  localparam int T_W      = 22;
  localparam int REG_IDX_W = 3;

  // Reciprocals for exact division by 10 and by 100 over the value ranges used.
  localparam int RECIP10      = 838861;
  localparam int RECIP10_SH   = 23;
  localparam int RECIP100     = 5368710;
  localparam int RECIP100_SH  = 29;
  localparam int SCALE_NUM    = 69;
  localparam int ROUND_BIAS   = 12800;
  localparam int SAT_POS_T    = 3276800;
  localparam int SAT_NEG_T    = 3276900;

  localparam logic [15:0] ERR_THR_RESET = 16'd50;
  localparam logic [15:0] WINDUP_RESET  = 16'd60;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_ERR_THR    = 3'd3,
    REG_WINDUP     = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_WMUL,
    OP_WCHK,
    OP_DMUL,
    OP_DAPPLY,
    OP_PMUL,
    OP_IMUL,
    OP_DERMUL,
    OP_SUM,
    OP_SCALE,
    OP_CLAMP,
    OP_QMUL,
    OP_FIN
  } op_t;

  typedef struct packed {
    logic in_valid;
    logic in_update;
    logic out_blocked;
  } sts_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_prop;
    logic signed [GAIN_W-1:0] gain_integ;
    logic signed [GAIN_W-1:0] gain_deriv;
    logic [15:0]              err_thr;
    logic [15:0]              windup_lim;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/mcpid_ctrl.sv
`default_nettype none

module mcpid_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  mcpid_pkg::sts_t    sts,
  output mcpid_pkg::op_t     op,
  output logic               in_ready
);
  import mcpid_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_WMUL,
    ST_WCHK,
    ST_DMUL,
    ST_DAPPLY,
    ST_PMUL,
    ST_IMUL,
    ST_DERMUL,
    ST_SUM,
    ST_SCALE,
    ST_CLAMP,
    ST_QMUL,
    ST_FIN
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (sts.in_valid && sts.in_update) state_r <= ST_ERR;
        end
        ST_ERR:    state_r <= ST_WMUL;
        ST_WMUL:   state_r <= ST_WCHK;
        ST_WCHK:   state_r <= ST_DMUL;
        ST_DMUL:   state_r <= ST_DAPPLY;
        ST_DAPPLY: state_r <= ST_PMUL;
        ST_PMUL:   state_r <= ST_IMUL;
        ST_IMUL:   state_r <= ST_DERMUL;
        ST_DERMUL: state_r <= ST_SUM;
        ST_SUM:    state_r <= ST_SCALE;
        ST_SCALE:  state_r <= ST_CLAMP;
        ST_CLAMP:  state_r <= ST_QMUL;
        ST_QMUL:   state_r <= ST_FIN;
        ST_FIN: begin
          if (!sts.out_blocked) state_r <= ST_IDLE;
        end
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    case (state_r)
      ST_IDLE:   op = sts.in_valid ? OP_LOAD : OP_NONE;
      ST_ERR:    op = OP_ERR;
      ST_WMUL:   op = OP_WMUL;
      ST_WCHK:   op = OP_WCHK;
      ST_DMUL:   op = OP_DMUL;
      ST_DAPPLY: op = OP_DAPPLY;
      ST_PMUL:   op = OP_PMUL;
      ST_IMUL:   op = OP_IMUL;
      ST_DERMUL: op = OP_DERMUL;
      ST_SUM:    op = OP_SUM;
      ST_SCALE:  op = OP_SCALE;
      ST_CLAMP:  op = OP_CLAMP;
      ST_QMUL:   op = OP_QMUL;
      ST_FIN:    op = sts.out_blocked ? OP_NONE : OP_FIN;
      default:   op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/mcpid_dp.sv
`default_nettype none

module mcpid_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  mcpid_pkg::op_t                          op,
  input  mcpid_pkg::cfg_t                         cfg,
  input  wire logic                               in_cmd,
  input  wire logic [mcpid_pkg::CH_W-1:0]         in_channel,
  input  wire logic signed [mcpid_pkg::VAL_W-1:0] in_value,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic [mcpid_pkg::CH_W-1:0]              out_channel,
  output logic signed [mcpid_pkg::VAL_W-1:0]      out_drive,
  output logic                                    out_sat
);
  import mcpid_pkg::*;

  // Per-channel state.
  logic signed [VAL_W-1:0] target_mem [CHANNELS];
  logic signed [INT_W-1:0] integ_mem  [CHANNELS];
  logic signed [ERR_W-1:0] last_mem   [CHANNELS];

  logic [CH_W-1:0]          ch_r;
  logic signed [VAL_W-1:0]  target_r;
  logic signed [VAL_W-1:0]  meas_r;
  logic signed [ERR_W-1:0]  last_r;
  logic signed [INT_W-1:0]  i_r;
  logic signed [ERR_W-1:0]  e_r;
  logic signed [DIFF_W-1:0] d_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [N_W-1:0]    n_r;
  logic [M9_W-1:0]          m9_r;
  logic                     i_neg_r;
  logic                     decay_r;
  logic [T_W-1:0]           t_r;
  logic                     neg_r;
  logic                     sat_r;

  logic                     out_valid_r;
  logic [CH_W-1:0]          out_channel_r;
  logic signed [VAL_W-1:0]  out_drive_r;
  logic                     out_sat_r;

  logic signed [ERR_W-1:0]  e_now;
  logic signed [DIFF_W-1:0] d_now;
  logic [ERR_W-1:0]         e_mag;
  logic [DIFF_W-1:0]        d_mag;
  logic                     refresh;
  logic signed [WPROD_W-1:0] wprod;
  logic [WPROD_W-1:0]       wprod_mag;
  logic [INT_W-1:0]         i_mag;
  logic [INT_W-1:0]         dec_q;
  logic signed [INT_W-1:0]  i_new;
  logic signed [SUM_W-1:0]  prod_low;
  logic [N_W-1:0]           n_mag;
  logic [N_W-9:0]           t_full;
  logic                     sat_now;
  logic [VAL_W-1:0]         q_div;
  logic signed [VAL_W-1:0]  drive_now;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     ch_ok;

  assign ch_ok = (int'(in_channel) < CHANNELS);

  // Error, error change and the integral refresh test.
  assign e_now   = ERR_W'(target_r) - ERR_W'(meas_r);
  assign d_now   = DIFF_W'(e_now) - DIFF_W'(last_r);
  assign e_mag   = e_now[ERR_W-1] ? ERR_W'(-e_now) : ERR_W'(e_now);
  assign d_mag   = d_now[DIFF_W-1] ? DIFF_W'(-d_now) : DIFF_W'(d_now);
  assign refresh = (e_mag <= {1'b0, cfg.err_thr}) && (d_mag <= {2'b00, cfg.err_thr});

  // Windup test on the registered integral product.
  assign wprod     = prod_r[WPROD_W-1:0];
  assign wprod_mag = wprod[WPROD_W-1] ? WPROD_W'(-wprod) : WPROD_W'(wprod);
  assign i_mag     = i_r[INT_W-1] ? INT_W'(-i_r) : INT_W'(i_r);

  // Decay: |I|*9/10 from the reciprocal product, sign put back afterwards.
  assign dec_q = prod_r[RECIP10_SH +: INT_W];
  assign i_new = decay_r ? (i_neg_r ? INT_W'(-$signed(dec_q)) : $signed(dec_q)) : i_r;

  assign prod_low = prod_r[SUM_W-1:0];

  // Scaling by 69/25600 with truncation towards zero, clamped to 16 bits.
  assign n_mag   = n_r[N_W-1] ? N_W'(-n_r) : N_W'(n_r);
  assign t_full  = n_mag[N_W-1:8];
  assign sat_now = n_r[N_W-1] ? (t_full >= (N_W-8)'(SAT_NEG_T))
                              : (t_full >= (N_W-8)'(SAT_POS_T));

  assign q_div = prod_r[RECIP100_SH +: VAL_W];
  always_comb begin
    if (sat_r) begin
      drive_now = neg_r ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      drive_now = neg_r ? VAL_W'(-$signed(q_div)) : $signed(q_div);
    end
  end

  // The one shared multiplier.
  always_comb begin
    case (op)
      OP_WMUL, OP_IMUL: begin
        mul_a = MUL_W'(cfg.gain_integ);
        mul_b = MUL_W'(i_r);
      end
      OP_DMUL: begin
        mul_a = $signed({{(MUL_W-M9_W){1'b0}}, m9_r});
        mul_b = MUL_W'(RECIP10);
      end
      OP_PMUL: begin
        mul_a = MUL_W'(cfg.gain_prop);
        mul_b = MUL_W'(e_r);
      end
      OP_DERMUL: begin
        mul_a = MUL_W'(cfg.gain_deriv);
        mul_b = MUL_W'(d_r);
      end
      OP_QMUL: begin
        mul_a = $signed({{(MUL_W-T_W){1'b0}}, t_r});
        mul_b = MUL_W'(RECIP100);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CHANNELS; k++) begin
        target_mem[k] <= '0;
        integ_mem[k]  <= '0;
        last_mem[k]   <= '0;
      end
    end else begin
      if (op == OP_LOAD && ch_ok && !in_cmd) begin
        target_mem[in_channel] <= in_value;
        integ_mem[in_channel]  <= '0;
      end
      if (op == OP_DAPPLY) begin
        integ_mem[ch_r] <= i_new;
        last_mem[ch_r]  <= e_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        ch_r     <= in_channel;
        meas_r   <= in_value;
        target_r <= target_mem[in_channel];
        i_r      <= integ_mem[in_channel];
        last_r   <= last_mem[in_channel];
      end
      OP_ERR: begin
        e_r <= e_now;
        d_r <= d_now;
        if (refresh) i_r <= e_now;
      end
      OP_WMUL: prod_r <= mul_p;
      OP_WCHK: begin
        decay_r <= (wprod_mag >= WPROD_W'({cfg.windup_lim, 8'h00}));
        m9_r    <= M9_W'({i_mag, 3'b000}) + M9_W'(i_mag);
        i_neg_r <= i_r[INT_W-1];
      end
      OP_DMUL:   prod_r <= mul_p;
      OP_DAPPLY: i_r    <= i_new;
      OP_PMUL:   prod_r <= mul_p;
      OP_IMUL: begin
        prod_r <= mul_p;
        acc_r  <= prod_low;
      end
      OP_DERMUL: begin
        prod_r <= mul_p;
        acc_r  <= acc_r + prod_low;
      end
      OP_SUM:    acc_r <= acc_r + prod_low;
      OP_SCALE: begin
        n_r <= (N_W'(acc_r) <<< 6) + (N_W'(acc_r) <<< 2) + N_W'(acc_r)
             + N_W'(ROUND_BIAS);
      end
      OP_CLAMP: begin
        neg_r <= n_r[N_W-1];
        sat_r <= sat_now;
        t_r   <= t_full[T_W-1:0];
      end
      OP_QMUL:   prod_r <= mul_p;
      default: ;
    endcase
  end

  // Output register: holds a finished transaction until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_FIN) begin
      out_channel_r <= ch_r;
      out_drive_r   <= drive_now;
      out_sat_r     <= sat_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_drive   = out_drive_r;
  assign out_sat     = out_sat_r;

endmodule

`default_nettype wire

FILE: rtl/multi_channel_position_pid_unit.sv
// Eight-channel position PID with integral anti-windup. A set-target
// transaction (in_tuser = 0) stores the channel's target and clears its
// integral in the cycle it is accepted, giving no result. An update
// transaction (in_tuser = 1) carries the measured position and yields one
// drive transaction after the sequencer has run its states from ST_ERR to
// ST_FIN; no new input is taken until it returns to idle. The block has
// a single shared 24x24 multiplier which the sequencer uses six times per
// update (windup test, decay by nine tenths, the three gain terms and the
// final divide by 100). A finished result waits in the output register, so a
// stalled sink only holds the block once a second result is ready. Gains are
// signed Q8.8; the drive is rounded, truncated towards zero and clipped to
// 16 bits, with out_tuser flagging the clip. Configuration writes take effect
// at once and should only be made while the block is idle.
`default_nettype none

module multi_channel_position_pid_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [2:0] channel, [18:3] value, rest zero
  input  wire logic        in_tuser,   // [0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [2:0] out_channel, [18:3] drive, rest zero
  output logic             out_tuser,  // [0] saturated
  input  wire logic        cfg_we,
  input  wire logic [mcpid_pkg::REG_IDX_W-1:0] cfg_addr,
  input  wire logic [15:0] cfg_wdata
);
  import mcpid_pkg::*;

  cfg_t                    cfg_r;
  sts_t                    sts;
  op_t                     op;
  logic [CH_W-1:0]         in_channel;
  logic signed [VAL_W-1:0] in_value;
  logic [CH_W-1:0]         out_channel;
  logic signed [VAL_W-1:0] out_drive;
  logic                    out_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop  <= '0;
      cfg_r.gain_integ <= '0;
      cfg_r.gain_deriv <= '0;
      cfg_r.err_thr    <= ERR_THR_RESET;
      cfg_r.windup_lim <= WINDUP_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_GAIN_PROP:  cfg_r.gain_prop  <= $signed(cfg_wdata);
        REG_GAIN_INTEG: cfg_r.gain_integ <= $signed(cfg_wdata);
        REG_GAIN_DERIV: cfg_r.gain_deriv <= $signed(cfg_wdata);
        REG_ERR_THR:    cfg_r.err_thr    <= cfg_wdata;
        REG_WINDUP:     cfg_r.windup_lim <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_channel = in_tdata[CH_W-1:0];
  assign in_value   = $signed(in_tdata[CH_W +: VAL_W]);

  assign sts.in_valid    = in_tvalid;
  assign sts.in_update   = in_tuser && (int'(in_channel) < CHANNELS);
  assign sts.out_blocked = out_tvalid && !out_tready;

  mcpid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .op       (op),
    .in_ready (in_tready)
  );

  mcpid_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .cfg         (cfg_r),
    .in_cmd      (in_tuser),
    .in_channel  (in_channel),
    .in_value    (in_value),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_channel (out_channel),
    .out_drive   (out_drive),
    .out_sat     (out_sat)
  );

  assign out_tdata = {5'b00000, out_drive, out_channel};
  assign out_tuser = out_sat;

endmodule

`default_nettype wire

FILE: rtl/mcpid_chk.sv
`default_nettype none

module mcpid_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tuser
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before it was taken");

  // An update keeps the input closed while it is being worked on.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input accepted during an update");

  // A set-target transaction never produces a result.
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("result produced by a set-target transaction");

  // A clipped drive sits at one of the two range limits.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[18:3] == 16'h7fff) || (out_tdata[18:3] == 16'h8000))
    else $error("saturation flag set on an unclipped drive");

endmodule

bind multi_channel_position_pid_unit mcpid_chk u_mcpid_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
